>>> hw/rtl/pmmp_pkg.sv
`timescale 1ns / 1ps

package pmmp_pkg;

	localparam int MAX_LEN_DEF = 32;
	localparam int CW          = 31;  // coefficient / modulus width
	localparam int DW          = 6;   // degree width
	localparam logic [CW-1:0] MOD_RESET = CW'(998244353);

	typedef struct packed {
		logic          operation;
		logic [CW-1:0] coefficient;
		logic          last_coefficient;
	} in_item_t;

	typedef struct packed {
		logic [CW-1:0] product_coefficient;
		logic [DW-1:0] degree;
		logic          last_of_run;
		logic          truncated;
	} out_item_t;

	// engine operations
	typedef enum logic [1:0] {
		M_RED_IN = 2'd0,  // latched input mod m
		M_RED_B  = 2'd1,  // b read data mod m
		M_MUL_B  = 2'd2,  // a * b mod m, b already below m
		M_MUL_R  = 2'd3   // a * (reduced b held in r) mod m
	} eng_mode_t;

	typedef struct packed {
		logic      eng_start;
		eng_mode_t eng_mode;
		logic      wr_a;
		logic      wr_b;
		logic      acc_add;
		logic      acc_clr;
	} dp_cmd_t;

	typedef struct packed {
		logic eng_done;
		logic b_ge_m;
	} dp_stat_t;

	typedef struct packed {
		logic          strobe;
		logic [DW-1:0] degree;
		logic          last_of_run;
		logic          truncated;
	} emit_t;

endpackage

>>> hw/rtl/pmmp_datapath.sv
`timescale 1ns / 1ps

module pmmp_datapath import pmmp_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF,
	parameter int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [CW-1:0] cfg_wdata,
	input  logic          take,
	input  logic [CW-1:0] coefficient,
	input  dp_cmd_t       cmd,
	input  logic [AW-1:0] addr_a,
	input  logic [AW-1:0] addr_b,
	output dp_stat_t      stat,
	output logic [CW-1:0] acc
);

	logic [CW-1:0] mod_q;
	logic [CW-1:0] m_eff;
	logic [CW-1:0] unit;
	logic [CW-1:0] in_q;
	logic [CW-1:0] a_mem [MAX_LEN];
	logic [CW-1:0] b_mem [MAX_LEN];
	logic [CW-1:0] a_rd_q, b_rd_q;
	logic [CW-1:0] x_q, y_q, r_q, acc_q;
	logic [4:0]    cnt_q;
	logic          busy_q, done_q;
	logic [CW:0]   r2, r2m, t, tm, s;

	assign m_eff = (mod_q == '0) ? CW'(1) : mod_q;
	assign unit  = (m_eff == CW'(1)) ? '0 : CW'(1);

	// one shift-add step: r = (2r + bit*y) mod m
	always_comb begin
		r2  = {r_q, 1'b0};
		r2m = (r2 >= {1'b0, m_eff}) ? r2 - {1'b0, m_eff} : r2;
		t   = r2m + (x_q[CW-1] ? {1'b0, y_q} : '0);
		tm  = (t >= {1'b0, m_eff}) ? t - {1'b0, m_eff} : t;
		s   = {1'b0, acc_q} + {1'b0, r_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q  <= MOD_RESET;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				mod_q <= cfg_wdata;
			end
			if (cmd.eng_start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(CW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
			if (cmd.acc_clr) begin
				acc_q <= '0;
			end else if (cmd.acc_add) begin
				acc_q <= (s >= {1'b0, m_eff}) ? CW'(s - {1'b0, m_eff}) : CW'(s);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			in_q <= coefficient;
		end
		if (cmd.eng_start) begin
			r_q <= '0;
			unique case (cmd.eng_mode)
				M_RED_IN: begin x_q <= in_q;   y_q <= unit;   end
				M_RED_B:  begin x_q <= b_rd_q; y_q <= unit;   end
				M_MUL_B:  begin x_q <= a_rd_q; y_q <= b_rd_q; end
				M_MUL_R:  begin x_q <= a_rd_q; y_q <= r_q;    end
				default:  begin x_q <= a_rd_q; y_q <= r_q;    end
			endcase
		end else if (busy_q) begin
			r_q <= CW'(tm);
			x_q <= {x_q[CW-2:0], 1'b0};
		end
	end

	// operand stores
	always_ff @(posedge clk) begin
		if (cmd.wr_a) begin
			a_mem[addr_a] <= r_q;
		end
		if (cmd.wr_b) begin
			b_mem[addr_b] <= r_q;
		end
		a_rd_q <= a_mem[addr_a];
		b_rd_q <= b_mem[addr_b];
	end

	assign stat.eng_done = done_q;
	assign stat.b_ge_m   = (b_rd_q >= m_eff);
	assign acc           = acc_q;

endmodule

>>> hw/rtl/pmmp_ctrl.sv
`timescale 1ns / 1ps

module pmmp_ctrl import pmmp_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF,
	parameter int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  in_item_t      item,
	output logic          busy,
	output dp_cmd_t       cmd,
	output logic [AW-1:0] addr_a,
	output logic [AW-1:0] addr_b,
	input  dp_stat_t      stat,
	output emit_t         emit
);

	localparam int CNTW = $clog2(MAX_LEN + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_LSTART, S_LWAIT, S_PAIR, S_RD, S_CHK, S_WRED, S_WMUL, S_EMIT
	} state_t;

	state_t          state_q;
	logic [CNTW-1:0] cnt_a_q, cnt_b_q;
	logic            cpl_a_q, cpl_b_q, ovf_q;
	logic            op_q, last_q;
	logic [AW-1:0]   i_q;
	logic [DW-1:0]   d_q;
	logic [DW-1:0]   total, j;
	logic            pair_ok, last_i, last_d;

	assign busy    = (state_q != S_IDLE);
	assign total   = DW'(cnt_a_q) + DW'(cnt_b_q) - DW'(1);
	assign j       = d_q - DW'(i_q);
	assign pair_ok = (DW'(i_q) <= d_q) && (j < DW'(cnt_b_q));
	assign last_i  = (CNTW'(i_q) == cnt_a_q - CNTW'(1));
	assign last_d  = (d_q == total - DW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd     <= '0;
			emit    <= '0;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			cpl_a_q <= 1'b0;
			cpl_b_q <= 1'b0;
			ovf_q   <= 1'b0;
			op_q    <= 1'b0;
			last_q  <= 1'b0;
			i_q     <= '0;
			d_q     <= '0;
			addr_a  <= '0;
			addr_b  <= '0;
		end else begin
			cmd         <= '0;
			emit.strobe <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q   <= item.operation;
						last_q <= item.last_coefficient;
						if (item.operation ? cpl_b_q : cpl_a_q) begin
							state_q <= S_IDLE;
						end else if ((item.operation ? cnt_b_q : cnt_a_q)
								< CNTW'(MAX_LEN)) begin
							state_q <= S_LSTART;
						end else begin
							ovf_q <= 1'b1;
							if (item.last_coefficient) begin
								if (item.operation) cpl_b_q <= 1'b1;
								else                cpl_a_q <= 1'b1;
								if (item.operation ? cpl_a_q : cpl_b_q) begin
									i_q     <= '0;
									d_q     <= '0;
									state_q <= S_PAIR;
								end
							end
						end
					end
				end
				S_LSTART: begin
					cmd.eng_start <= 1'b1;
					cmd.eng_mode  <= M_RED_IN;
					state_q       <= S_LWAIT;
				end
				S_LWAIT: begin
					if (stat.eng_done) begin
						if (op_q) begin
							cmd.wr_b <= 1'b1;
							addr_b   <= AW'(cnt_b_q);
							cnt_b_q  <= cnt_b_q + CNTW'(1);
							if (last_q) cpl_b_q <= 1'b1;
						end else begin
							cmd.wr_a <= 1'b1;
							addr_a   <= AW'(cnt_a_q);
							cnt_a_q  <= cnt_a_q + CNTW'(1);
							if (last_q) cpl_a_q <= 1'b1;
						end
						if (last_q && (op_q ? cpl_a_q : cpl_b_q)) begin
							i_q     <= '0;
							d_q     <= '0;
							state_q <= S_PAIR;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_PAIR: begin
					if (pair_ok) begin
						addr_a  <= i_q;
						addr_b  <= AW'(j);
						state_q <= S_RD;
					end else if (last_i) begin
						state_q <= S_EMIT;
					end else begin
						i_q <= i_q + AW'(1);
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					cmd.eng_start <= 1'b1;
					cmd.eng_mode  <= stat.b_ge_m ? M_RED_B : M_MUL_B;
					state_q       <= stat.b_ge_m ? S_WRED : S_WMUL;
				end
				S_WRED: begin
					if (stat.eng_done) begin
						cmd.eng_start <= 1'b1;
						cmd.eng_mode  <= M_MUL_R;
						state_q       <= S_WMUL;
					end
				end
				S_WMUL: begin
					if (stat.eng_done) begin
						cmd.acc_add <= 1'b1;
						if (last_i) begin
							state_q <= S_EMIT;
						end else begin
							i_q     <= i_q + AW'(1);
							state_q <= S_PAIR;
						end
					end
				end
				S_EMIT: begin
					emit.strobe      <= 1'b1;
					emit.degree      <= d_q;
					emit.last_of_run <= last_d;
					emit.truncated   <= ovf_q;
					cmd.acc_clr      <= 1'b1;
					i_q              <= '0;
					if (last_d) begin
						cnt_a_q <= '0;
						cnt_b_q <= '0;
						cpl_a_q <= 1'b0;
						cpl_b_q <= 1'b0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						d_q     <= d_q + DW'(1);
						state_q <= S_PAIR;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_b2b_result: assert property (@(posedge clk) disable iff (!arst_n)
		emit.strobe |=> !emit.strobe)
		else $error("results on consecutive cycles");

	a_one_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_a |-> !cmd.wr_b)
		else $error("both stores written at once");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_a_q <= CNTW'(MAX_LEN)) && (cnt_b_q <= CNTW'(MAX_LEN)))
		else $error("operand count beyond store depth");

	a_run_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.strobe && emit.last_of_run) |-> (cnt_a_q == '0 && cnt_b_q == '0 && !ovf_q))
		else $error("run state not cleared at end of run");

endmodule

>>> hw/rtl/poly_multiply_mod_prime_top.sv
`timescale 1ns / 1ps

// Schoolbook polynomial product modulo a programmable modulus. Items load
// coefficients of operand a (operation 0) or b (operation 1), lowest degree
// first; last_coefficient closes an operand. An item is taken when start is
// high and busy low. Each loaded coefficient is reduced by a bit-serial
// shift-add engine (31 steps), and busy stays high while it runs.
// Once both operands are closed the block emits na+nb-1 results, lowest
// degree first, each on result/result_valid for exactly one cycle; the
// receiver cannot stall, so it must take every strobed result. Each
// product term is computed in the same engine; a stored b value that is
// not below the current modulus is reduced there first, and index pairs
// that form no term are skipped. Coefficients past MAX_LEN are dropped
// and flag truncated on every result of that run. The modulus must be
// written via cfg_we/cfg_wdata only while idle; the block itself does
// not enforce this. Zero acts as one.
module poly_multiply_mod_prime_top import pmmp_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  in_item_t      item,
	output logic          result_valid,
	output out_item_t     result,
	input  logic          cfg_we,
	input  logic [CW-1:0] cfg_wdata
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	dp_cmd_t       cmd;
	dp_stat_t      stat;
	emit_t         emit;
	logic [AW-1:0] addr_a, addr_b;
	logic [CW-1:0] acc;
	logic          take;

	// item accepted this edge
	assign take = start && !busy;

	pmmp_ctrl #(.MAX_LEN(MAX_LEN), .AW(AW)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.cmd    (cmd),
		.addr_a (addr_a),
		.addr_b (addr_b),
		.stat   (stat),
		.emit   (emit)
	);

	pmmp_datapath #(.MAX_LEN(MAX_LEN), .AW(AW)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.take        (take),
		.coefficient (item.coefficient),
		.cmd         (cmd),
		.addr_a      (addr_a),
		.addr_b      (addr_b),
		.stat        (stat),
		.acc         (acc)
	);

	// accumulator is final when the strobe shows
	assign result_valid               = emit.strobe;
	assign result.product_coefficient = acc;
	assign result.degree              = emit.degree;
	assign result.last_of_run         = emit.last_of_run;
	assign result.truncated           = emit.truncated;

endmodule
